>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of the alarm scheduler.
// No dependencies; included by the files that hold assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check that is switched off while reset is active.
`define WATS_ASSERT_RST(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("scheduler check failed");

// Clocked property check that also holds during reset.
`define WATS_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("scheduler check failed");

`endif

>>> hdl/wats_pkg.sv
// Package for the weekly alarm table scheduler: widths, constants, commands,
// state encoding and the structs passed between the sequencer and the evaluator.
// No dependencies.
`timescale 1ns / 1ps

package wats_pkg;

	localparam int MAX_ALARMS = 32;
	localparam int IDX_W      = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;

	localparam int SLOT_W  = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int MASK_W  = 7;
	localparam int MS_W    = 63;
	localparam int GRACE_W = 32;
	localparam int WD_W    = 3;
	localparam int CMD_W   = 3;

	// Seconds within a day, distance in seconds, distance in ms.
	localparam int CUR_W  = 17;
	localparam int DIST_W = 21;
	localparam int DMS_W  = 31;

	localparam int SEC_PER_MIN   = 60;
	localparam int SEC_PER_HOUR  = 3600;
	localparam int SEC_PER_DAY   = 24 * 60 * 60;
	localparam int MS_PER_SEC    = 1000;
	localparam int DAYS_PER_WEEK = 7;
	localparam int MAX_HOUR      = 23;
	localparam int MAX_MINUTE    = 59;
	localparam int MAX_WEEKDAY   = 7;

	localparam logic [MS_W-1:0] MAX63 = {MS_W{1'b1}};

	localparam logic [CMD_W-1:0] CMD_ADD       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UPDATE    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RECONCILE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESP
	} state_t;

	// Stored alarm time and repeat mask of one slot.
	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic [MIN_W-1:0]  minute;
		logic [HOUR_W-1:0] hour;
	} setting_t;

	// One slot entering the evaluator.
	typedef struct packed {
		logic              vld;
		logic [IDX_W-1:0]  slot;
		logic              live;
		setting_t          set;
		logic [MS_W-1:0]   fire;
	} slot_in_t;

	// One evaluated slot leaving the evaluator.
	typedef struct packed {
		logic              vld;
		logic [IDX_W-1:0]  slot;
		logic              cand;
		logic              expire;
		logic [MS_W-1:0]   fire;
	} slot_out_t;

endpackage

>>> hdl/weekly_alarm_table_scheduler_top.sv
// Top level of the weekly alarm table scheduler: command sequencer, slot
// tables and result registers. Depends on wats_pkg and wats_eval.
`timescale 1ns / 1ps

// Usage.
// A command is transferred at a rising edge with start high and busy low; its
// fields are sampled at that edge only. Busy stays high until the result is out.
// Exactly one result per command appears on ok, found, next_slot and
// next_fire_ms for one cycle, marked by done; the receiver cannot stall it.
// Add, update, remove and unknown commands show done in the cycle right after
// the transfer; the next command can be taken the cycle after done.
// Reconcile and query walk every slot through the shared evaluator, one slot per
// cycle, through the single table read port and the three-stage evaluator that
// all slots share.
// grace_we writes grace_ms at any edge; it must only change while idle.
// Reset clears every slot's valid and enable flag, grace_ms and the sequencer;
// no clearing pass runs, so a command can be taken in the first cycle after reset.

module weekly_alarm_table_scheduler_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               grace_we,
	input  logic [wats_pkg::GRACE_W-1:0]       grace_wdata,
	input  logic                               start,
	output logic                               busy,
	input  logic [wats_pkg::CMD_W-1:0]         command,
	input  logic [wats_pkg::SLOT_W-1:0]        slot,
	input  logic [wats_pkg::HOUR_W-1:0]        alarm_hour,
	input  logic [wats_pkg::MIN_W-1:0]         alarm_minute,
	input  logic [wats_pkg::MASK_W-1:0]        repeat_mask,
	input  logic                               alarm_enabled,
	input  logic [wats_pkg::MS_W-1:0]          one_shot_ms,
	input  logic [wats_pkg::MS_W-1:0]          now_ms,
	input  logic [wats_pkg::WD_W-1:0]          now_weekday,
	input  logic [wats_pkg::HOUR_W-1:0]        now_hour,
	input  logic [wats_pkg::MIN_W-1:0]         now_minute,
	input  logic [wats_pkg::MIN_W-1:0]         now_second,
	output logic                               done,
	output logic                               ok,
	output logic                               found,
	output logic [wats_pkg::SLOT_W-1:0]        next_slot,
	output logic [wats_pkg::MS_W-1:0]          next_fire_ms
);

	wats_pkg::state_t                   state_q, state_d;
	logic [wats_pkg::CMD_W-1:0]         cmd_q;
	logic [wats_pkg::MS_W-1:0]          now_q;
	logic [wats_pkg::CUR_W-1:0]         cur_q;
	logic [wats_pkg::WD_W-1:0]          wdi_q;
	logic [wats_pkg::GRACE_W-1:0]       grace_q;
	logic [wats_pkg::IDX_W-1:0]         idx_q;
	logic [wats_pkg::MAX_ALARMS-1:0]    vld_q, en_q;
	logic                               ok_q, found_q;
	logic [wats_pkg::IDX_W-1:0]         best_slot_q;
	logic [wats_pkg::MS_W-1:0]          best_q;

	wats_pkg::setting_t                 set_mem [wats_pkg::MAX_ALARMS];
	logic [wats_pkg::MS_W-1:0]          fire_mem [wats_pkg::MAX_ALARMS];
	wats_pkg::setting_t                 set_rd_q;
	logic [wats_pkg::MS_W-1:0]          fire_rd_q;
	logic                               vld_s1, live_s1;
	logic [wats_pkg::IDX_W-1:0]         slot_s1;

	wats_pkg::slot_in_t                 ev_in;
	wats_pkg::slot_out_t                ev_out;
	logic                               pipe_busy;

	logic                               accept, in_range, slot_vld, last_idx;
	logic [wats_pkg::IDX_W-1:0]         widx;
	wats_pkg::setting_t                 wset;
	logic [wats_pkg::MS_W-1:0]          wfire;
	logic                               do_write;
	logic [wats_pkg::HOUR_W-1:0]        nh;
	logic [wats_pkg::MIN_W-1:0]         nm, ns;

	assign accept   = start && (state_q == wats_pkg::ST_IDLE);
	assign busy     = (state_q != wats_pkg::ST_IDLE);
	assign last_idx = (idx_q == wats_pkg::IDX_W'(wats_pkg::MAX_ALARMS - 1));

	// Slot addressing and the normalized alarm written by add and update.
	always_comb begin
		in_range = (32'(slot) < 32'(wats_pkg::MAX_ALARMS));
		widx     = wats_pkg::IDX_W'(slot);
		slot_vld = in_range && vld_q[widx];
		wset.hour   = (alarm_hour > wats_pkg::HOUR_W'(wats_pkg::MAX_HOUR))
			? wats_pkg::HOUR_W'(wats_pkg::MAX_HOUR) : alarm_hour;
		wset.minute = (alarm_minute > wats_pkg::MIN_W'(wats_pkg::MAX_MINUTE))
			? wats_pkg::MIN_W'(wats_pkg::MAX_MINUTE) : alarm_minute;
		wset.mask   = repeat_mask;
		wfire       = (repeat_mask != '0) ? '0 : one_shot_ms;
		do_write    = accept && in_range
			&& (((command == wats_pkg::CMD_ADD) && !vld_q[widx])
			|| ((command == wats_pkg::CMD_UPDATE) && vld_q[widx]));
		nh = (now_hour > wats_pkg::HOUR_W'(wats_pkg::MAX_HOUR))
			? wats_pkg::HOUR_W'(wats_pkg::MAX_HOUR) : now_hour;
		nm = (now_minute > wats_pkg::MIN_W'(wats_pkg::MAX_MINUTE))
			? wats_pkg::MIN_W'(wats_pkg::MAX_MINUTE) : now_minute;
		ns = (now_second > wats_pkg::MIN_W'(wats_pkg::MAX_MINUTE))
			? wats_pkg::MIN_W'(wats_pkg::MAX_MINUTE) : now_second;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wats_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			wats_pkg::ST_IDLE: begin
				if (start) begin
					if (command == wats_pkg::CMD_RECONCILE || command == wats_pkg::CMD_QUERY) begin
						state_d = wats_pkg::ST_SCAN;
					end else begin
						state_d = wats_pkg::ST_RESP;
					end
				end
			end
			wats_pkg::ST_SCAN: begin
				if (last_idx) begin
					state_d = wats_pkg::ST_DRAIN;
				end
			end
			wats_pkg::ST_DRAIN: begin
				if (!vld_s1 && !pipe_busy) begin
					state_d = wats_pkg::ST_RESP;
				end
			end
			wats_pkg::ST_RESP: begin
				state_d = wats_pkg::ST_IDLE;
			end
			default: begin
				state_d = wats_pkg::ST_IDLE;
			end
		endcase
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grace_q <= '0;
		end else if (grace_we) begin
			grace_q <= grace_wdata;
		end
	end

	// Command context captured at the transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			now_q <= now_ms;
			cur_q <= wats_pkg::CUR_W'(nh) * wats_pkg::CUR_W'(wats_pkg::SEC_PER_HOUR)
				+ wats_pkg::CUR_W'(nm) * wats_pkg::CUR_W'(wats_pkg::SEC_PER_MIN)
				+ wats_pkg::CUR_W'(ns);
			wdi_q <= (now_weekday == '0) ? '0 : now_weekday - 1'b1;
		end
	end

	// Slot flags, scan counter and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			en_q        <= '0;
			idx_q       <= '0;
			ok_q        <= 1'b0;
			found_q     <= 1'b0;
			best_slot_q <= '0;
			best_q      <= '0;
		end else begin
			if (accept) begin
				idx_q       <= '0;
				ok_q        <= 1'b0;
				found_q     <= 1'b0;
				best_slot_q <= '0;
				best_q      <= '0;
				if (do_write) begin
					vld_q[widx] <= 1'b1;
					en_q[widx]  <= alarm_enabled;
					ok_q        <= 1'b1;
				end else if (command == wats_pkg::CMD_REMOVE && slot_vld) begin
					vld_q[widx] <= 1'b0;
					en_q[widx]  <= 1'b0;
					ok_q        <= 1'b1;
				end
			end
			if (state_q == wats_pkg::ST_SCAN) begin
				idx_q <= idx_q + 1'b1;
			end
			// Fold each evaluated slot into the running result.
			if (ev_out.vld) begin
				if (cmd_q == wats_pkg::CMD_RECONCILE && ev_out.expire) begin
					en_q[ev_out.slot] <= 1'b0;
					ok_q              <= 1'b1;
				end
				if (cmd_q == wats_pkg::CMD_QUERY && ev_out.cand && ev_out.fire > now_q
					&& (!found_q || ev_out.fire < best_q)) begin
					found_q     <= 1'b1;
					best_q      <= ev_out.fire;
					best_slot_q <= ev_out.slot;
				end
			end
		end
	end

	// Slot tables: written by add and update, read once per slot during a scan.
	always_ff @(posedge clk) begin
		if (do_write) begin
			set_mem[widx]  <= wset;
			fire_mem[widx] <= wfire;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == wats_pkg::ST_SCAN) begin
			set_rd_q  <= set_mem[idx_q];
			fire_rd_q <= fire_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == wats_pkg::ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= idx_q;
		live_s1 <= vld_q[idx_q] && en_q[idx_q];
	end

	always_comb begin
		ev_in.vld  = vld_s1;
		ev_in.slot = slot_s1;
		ev_in.live = live_s1;
		ev_in.set  = set_rd_q;
		ev_in.fire = fire_rd_q;
	end

	wats_eval u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.slot_in   (ev_in),
		.now_ms    (now_q),
		.cur_sec   (cur_q),
		.wd_idx    (wdi_q),
		.grace     (grace_q),
		.slot_out  (ev_out),
		.pipe_busy (pipe_busy)
	);

	// Result outputs.
	assign done         = (state_q == wats_pkg::ST_RESP);
	assign ok           = ok_q;
	assign found        = found_q;
	assign next_slot    = wats_pkg::SLOT_W'(best_slot_q);
	assign next_fire_ms = best_q;

endmodule

>>> hdl/wats_eval.sv
// Shared slot evaluator: a three-stage pipeline that computes the next fire
// time of one slot and its one-shot expiry test. Depends on wats_pkg.
`timescale 1ns / 1ps

module wats_eval (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wats_pkg::slot_in_t              slot_in,
	input  logic [wats_pkg::MS_W-1:0]       now_ms,
	input  logic [wats_pkg::CUR_W-1:0]      cur_sec,
	input  logic [wats_pkg::WD_W-1:0]       wd_idx,
	input  logic [wats_pkg::GRACE_W-1:0]    grace,
	output wats_pkg::slot_out_t             slot_out,
	output logic                            pipe_busy
);

	// Carriers into stage 2 and stage 3, and the output register.
	logic                         vld_s2, live_s2, rep_s2;
	logic [wats_pkg::IDX_W-1:0]   slot_s2;
	logic [wats_pkg::MS_W-1:0]    fire_s2;
	logic [wats_pkg::DIST_W-1:0]  dist_s2;

	logic                         vld_s3, live_s3, rep_s3;
	logic [wats_pkg::IDX_W-1:0]   slot_s3;
	logic [wats_pkg::MS_W-1:0]    fire_s3;
	logic [wats_pkg::DMS_W-1:0]   dms_s3;
	logic [wats_pkg::MS_W:0]      dl_s3;

	logic                         vld_s4, cand_s4, expire_s4;
	logic [wats_pkg::IDX_W-1:0]   slot_s4;
	logic [wats_pkg::MS_W-1:0]    fire_s4;

	logic [wats_pkg::CUR_W-1:0]   target;
	logic [wats_pkg::WD_W-1:0]    day;
	logic [wats_pkg::DIST_W-1:0]  dist_sec;
	logic [wats_pkg::MS_W:0]      sum;
	logic [wats_pkg::MS_W-1:0]    rep_fire, dl_sat;

	// Stage 1 logic: alarm time of day, first matching weekday, distance in seconds.
	always_comb begin
		logic [wats_pkg::WD_W-1:0] idx;
		logic                      hit;
		target = wats_pkg::CUR_W'(slot_in.set.hour) * wats_pkg::CUR_W'(wats_pkg::SEC_PER_HOUR)
			+ wats_pkg::CUR_W'(slot_in.set.minute) * wats_pkg::CUR_W'(wats_pkg::SEC_PER_MIN);
		idx = wd_idx;
		hit = 1'b0;
		day = '0;
		for (int d = 0; d <= wats_pkg::DAYS_PER_WEEK; d++) begin
			if (!hit && slot_in.set.mask[idx] && !(d == 0 && target <= cur_sec)) begin
				hit = 1'b1;
				day = wats_pkg::WD_W'(d);
			end
			idx = (idx == wats_pkg::WD_W'(wats_pkg::DAYS_PER_WEEK - 1)) ? '0 : idx + 1'b1;
		end
		dist_sec = wats_pkg::DIST_W'(target)
			+ wats_pkg::DIST_W'(day) * wats_pkg::DIST_W'(wats_pkg::SEC_PER_DAY)
			- wats_pkg::DIST_W'(cur_sec);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= slot_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		slot_s2 <= slot_in.slot;
		live_s2 <= slot_in.live;
		rep_s2  <= (slot_in.set.mask != '0);
		fire_s2 <= slot_in.fire;
		dist_s2 <= dist_sec;
	end

	// Stage 2: distance to ms, and the one-shot deadline with grace.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		slot_s3 <= slot_s2;
		live_s3 <= live_s2;
		rep_s3  <= rep_s2;
		fire_s3 <= fire_s2;
		dms_s3  <= wats_pkg::DMS_W'(dist_s2) * wats_pkg::DMS_W'(wats_pkg::MS_PER_SEC);
		dl_s3   <= {1'b0, fire_s2} + (wats_pkg::MS_W+1)'(grace);
	end

	// Stage 3: absolute repeating fire time and the expiry compare.
	always_comb begin
		sum      = {1'b0, now_ms} + (wats_pkg::MS_W+1)'(dms_s3);
		rep_fire = sum[wats_pkg::MS_W] ? wats_pkg::MAX63 : sum[wats_pkg::MS_W-1:0];
		dl_sat   = dl_s3[wats_pkg::MS_W] ? wats_pkg::MAX63 : dl_s3[wats_pkg::MS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		slot_s4   <= slot_s3;
		cand_s4   <= live_s3;
		fire_s4   <= rep_s3 ? rep_fire : fire_s3;
		expire_s4 <= live_s3 && !rep_s3 && (fire_s3 == '0 || dl_sat <= now_ms);
	end

	// Evaluated slot toward the sequencer.
	always_comb begin
		slot_out.vld    = vld_s4;
		slot_out.slot   = slot_s4;
		slot_out.cand   = cand_s4;
		slot_out.expire = expire_s4;
		slot_out.fire   = fire_s4;
	end

	assign pipe_busy = vld_s2 | vld_s3 | vld_s4;

endmodule

>>> hdl/wats_checker.sv
// Port-level checker for the alarm scheduler and its bind to the top level.
// Depends on wats_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wats_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic                          done,
	input  logic                          found,
	input  logic [wats_pkg::SLOT_W-1:0]   next_slot,
	input  logic [wats_pkg::MS_W-1:0]     next_fire_ms
);

	// A result is shown for one cycle only.
	`WATS_ASSERT_RST(a_done_pulse, clk, arst_n, done |=> !done)

	// A result belongs to a command in flight.
	`WATS_ASSERT_RST(a_done_busy, clk, arst_n, done |-> busy)

	// A transfer makes the block busy in the next cycle.
	`WATS_ASSERT_RST(a_start_busy, clk, arst_n, (start && !busy) |=> busy)

	// Without a hit the slot and time read zero; a hit has a nonzero time.
	`WATS_ASSERT_RST(a_empty_zero, clk, arst_n, (done && !found) |-> (next_slot == '0 && next_fire_ms == '0))
	`WATS_ASSERT_RST(a_hit_nonzero, clk, arst_n, (done && found) |-> (next_fire_ms != '0))

endmodule

bind weekly_alarm_table_scheduler_top wats_checker u_wats_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.found        (found),
	.next_slot    (next_slot),
	.next_fire_ms (next_fire_ms)
);

>>> tb/sv/tb.sv
// Self-checking testbench for the weekly alarm table scheduler.
// Drives a directed table and random commands, and checks every result against the
// in-bench table model or a fixed row's expectation. Depends on wats_pkg and the top.
`timescale 1ns / 1ps

module tb;
	import wats_pkg::*;

	localparam logic [CMD_W-1:0] CMD_BAD_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_BAD_HI = 3'd7;
	localparam int CYCLE_LIMIT = 800000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [SLOT_W-1:0] slot;
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic [MASK_W-1:0] mask;
		logic              en;
		logic [MS_W-1:0]   shot;
		logic [MS_W-1:0]   now;
		logic [WD_W-1:0]   wd;
		logic [HOUR_W-1:0] nh;
		logic [MIN_W-1:0]  nm;
		logic [MIN_W-1:0]  ns;
	} alarm_cmd_t;

	typedef struct {
		logic              ok;
		logic              found;
		logic [SLOT_W-1:0] nslot;
		logic [MS_W-1:0]   nfire;
	} alarm_res_t;

	typedef struct {
		alarm_cmd_t c;
		bit         fixed;
		alarm_res_t r;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic grace_we = 1'b0;
	logic [GRACE_W-1:0] grace_wdata = '0;
	logic start = 1'b0;
	logic [CMD_W-1:0] command = '0;
	logic [SLOT_W-1:0] slot = '0;
	logic [HOUR_W-1:0] alarm_hour = '0;
	logic [MIN_W-1:0] alarm_minute = '0;
	logic [MASK_W-1:0] repeat_mask = '0;
	logic alarm_enabled = 1'b0;
	logic [MS_W-1:0] one_shot_ms = '0;
	logic [MS_W-1:0] now_ms = '0;
	logic [WD_W-1:0] now_weekday = '0;
	logic [HOUR_W-1:0] now_hour = '0;
	logic [MIN_W-1:0] now_minute = '0;
	logic [MIN_W-1:0] now_second = '0;
	logic busy, done, ok, found;
	logic [SLOT_W-1:0] next_slot;
	logic [MS_W-1:0] next_fire_ms;

	weekly_alarm_table_scheduler_top dut (
		.clk(clk), .arst_n(arst_n), .grace_we(grace_we), .grace_wdata(grace_wdata),
		.start(start), .busy(busy), .command(command), .slot(slot),
		.alarm_hour(alarm_hour), .alarm_minute(alarm_minute), .repeat_mask(repeat_mask),
		.alarm_enabled(alarm_enabled), .one_shot_ms(one_shot_ms), .now_ms(now_ms),
		.now_weekday(now_weekday), .now_hour(now_hour), .now_minute(now_minute),
		.now_second(now_second), .done(done), .ok(ok), .found(found),
		.next_slot(next_slot), .next_fire_ms(next_fire_ms)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Model of the alarm table.
	logic              tbl_valid [MAX_ALARMS];
	logic              tbl_en [MAX_ALARMS];
	logic [HOUR_W-1:0] tbl_hour [MAX_ALARMS];
	logic [MIN_W-1:0]  tbl_min [MAX_ALARMS];
	logic [MASK_W-1:0] tbl_mask [MAX_ALARMS];
	logic [MS_W-1:0]   tbl_fire [MAX_ALARMS];
	logic [GRACE_W-1:0] grace_model = '0;

	alarm_res_t pending_results[$];
	table_row_t rows[$];
	int errors = 0;
	int cycles = 0;
	logic [MS_W-1:0] base_ms;

	function automatic logic [5:0] sat(logic [5:0] v, logic [5:0] hi);
		return (v > hi) ? hi : v;
	endfunction

	// Next absolute time at which a repeating slot fires, seen from the command's clock.
	function automatic logic [MS_W-1:0] repeat_fire_time(int i, alarm_cmd_t c);
		int wd, cur, tgt, day, w;
		logic [63:0] sum;
		wd = (c.wd > MAX_WEEKDAY) ? MAX_WEEKDAY : ((c.wd == 0) ? 1 : c.wd);
		cur = sat(c.nh, 6'(MAX_HOUR)) * SEC_PER_HOUR + sat(c.nm, 6'(MAX_MINUTE)) * SEC_PER_MIN
			+ sat(c.ns, 6'(MAX_MINUTE));
		tgt = tbl_hour[i] * SEC_PER_HOUR + tbl_min[i] * SEC_PER_MIN;
		for (day = 0; day <= DAYS_PER_WEEK; day++) begin
			w = ((wd - 1 + day) % DAYS_PER_WEEK) + 1;
			if (!tbl_mask[i][w-1]) continue;
			if (day == 0 && tgt <= cur) continue;
			break;
		end
		sum = {1'b0, c.now} + 64'(tgt + day * SEC_PER_DAY - cur) * MS_PER_SEC;
		return (sum > {1'b0, MAX63}) ? MAX63 : sum[MS_W-1:0];
	endfunction

	// Applies one command to the table model and returns its result.
	function automatic alarm_res_t apply_alarm_cmd(alarm_cmd_t c);
		alarm_res_t r;
		logic [63:0] deadline;
		logic [MS_W-1:0] f;
		r = '{default: '0};
		case (c.cmd)
			CMD_ADD, CMD_UPDATE: begin
				if (tbl_valid[c.slot] == (c.cmd == CMD_UPDATE)) begin
					tbl_valid[c.slot] = 1'b1;
					tbl_en[c.slot] = c.en;
					tbl_hour[c.slot] = HOUR_W'(sat(6'(c.hour), 6'(MAX_HOUR)));
					tbl_min[c.slot] = sat(c.minute, 6'(MAX_MINUTE));
					tbl_mask[c.slot] = c.mask;
					tbl_fire[c.slot] = (c.mask != 0) ? '0 : c.shot;
					r.ok = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (tbl_valid[c.slot]) begin
					tbl_valid[c.slot] = 1'b0;
					tbl_en[c.slot] = 1'b0;
					tbl_hour[c.slot] = '0;
					tbl_min[c.slot] = '0;
					tbl_mask[c.slot] = '0;
					tbl_fire[c.slot] = '0;
					r.ok = 1'b1;
				end
			end
			CMD_RECONCILE: begin
				for (int i = 0; i < MAX_ALARMS; i++) begin
					if (!tbl_valid[i] || !tbl_en[i] || tbl_mask[i] != 0) continue;
					deadline = {1'b0, tbl_fire[i]} + 64'(grace_model);
					if (deadline > {1'b0, MAX63}) deadline = {1'b0, MAX63};
					if (tbl_fire[i] == 0 || deadline <= {1'b0, c.now}) begin
						tbl_en[i] = 1'b0;
						r.ok = 1'b1;
					end
				end
			end
			CMD_QUERY: begin
				for (int i = 0; i < MAX_ALARMS; i++) begin
					if (!tbl_valid[i] || !tbl_en[i]) continue;
					f = (tbl_mask[i] != 0) ? repeat_fire_time(i, c) : tbl_fire[i];
					if (f <= c.now) continue;
					if (!r.found || f < r.nfire) begin
						r.found = 1'b1;
						r.nfire = f;
						r.nslot = SLOT_W'(i);
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [MS_W-1:0] got, logic [MS_W-1:0] want);
		$display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// Result checker; results cannot be held off, so every done cycle is a transfer.
	always @(posedge clk) begin
		alarm_res_t e;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end else if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("MISMATCH result with nothing pending at cycle %0d", cycles);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (ok !== e.ok) report_mismatch("ok", ok, e.ok);
				if (found !== e.found) report_mismatch("found", found, e.found);
				if (next_slot !== e.nslot) report_mismatch("next_slot", next_slot, e.nslot);
				if (next_fire_ms !== e.nfire)
					report_mismatch("next_fire_ms", next_fire_ms, e.nfire);
			end
		end
	end

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 4);
		return $urandom_range(10, 50);
	endfunction

	function automatic logic [MS_W-1:0] rand63();
		return {$urandom, $urandom} & MAX63;
	endfunction

	// Drives one command and waits for its transfer; called at a rising edge.
	task automatic send_cmd(alarm_cmd_t c, bit fixed, alarm_res_t want, bit idle_gaps);
		int gap;
		alarm_res_t r;
		gap = idle_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		command <= c.cmd;
		slot <= c.slot;
		alarm_hour <= c.hour;
		alarm_minute <= c.minute;
		repeat_mask <= c.mask;
		alarm_enabled <= c.en;
		one_shot_ms <= c.shot;
		now_ms <= c.now;
		now_weekday <= c.wd;
		now_hour <= c.nh;
		now_minute <= c.nm;
		now_second <= c.ns;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		r = apply_alarm_cmd(c);
		if (fixed) r = want;
		pending_results = {pending_results, r};
	endtask

	// Lets the block go idle, then writes the grace register.
	task automatic write_grace(logic [GRACE_W-1:0] v);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		grace_we <= 1'b1;
		grace_wdata <= v;
		@(posedge clk);
		grace_model = v;
		grace_we <= 1'b0;
	endtask

	function automatic alarm_cmd_t mk(logic [CMD_W-1:0] cmd, int s, int h, int m, int mask,
			bit en, logic [MS_W-1:0] shot, logic [MS_W-1:0] now, int wd, int nh, int nm,
			int ns);
		alarm_cmd_t c;
		c = '{cmd, s, h, m, mask, en, shot, now, wd, nh, nm, ns};
		return c;
	endfunction

	function automatic alarm_res_t rs(bit o, bit f, int s, logic [MS_W-1:0] t);
		alarm_res_t r;
		r = '{o, f, s, t};
		return r;
	endfunction

	// Appends one row to the directed table.
	function automatic void add_row(alarm_cmd_t c, bit fixed, alarm_res_t r);
		table_row_t row;
		row = '{c, fixed, r};
		rows = {rows, row};
	endfunction

	// Random command: mostly a few busy slots and times near a moving base.
	function automatic alarm_cmd_t random_cmd();
		alarm_cmd_t c;
		int p;
		p = $urandom_range(0, 99);
		c.cmd = (p < 25) ? CMD_ADD : (p < 45) ? CMD_UPDATE : (p < 57) ? CMD_REMOVE :
			(p < 72) ? CMD_RECONCILE : (p < 97) ? CMD_QUERY : $urandom_range(5, 7);
		c.slot = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 7) : $urandom_range(0, 31);
		c.hour = $urandom_range(0, 31);
		c.minute = $urandom_range(0, 63);
		p = $urandom_range(0, 99);
		c.mask = (p < 45) ? 0 : (p < 55) ? 7'h7f : $urandom_range(0, 127);
		c.en = ($urandom_range(0, 9) < 8);
		p = $urandom_range(0, 99);
		c.shot = (p < 70) ? base_ms + $urandom_range(0, 400000) - 200000 :
			(p < 80) ? '0 : (p < 88) ? MAX63 : rand63();
		base_ms = base_ms + $urandom_range(0, 20000);
		p = $urandom_range(0, 99);
		c.now = (p < 85) ? base_ms : (p < 90) ? MAX63 : (p < 93) ? '0 : rand63();
		c.wd = $urandom_range(0, 7);
		c.nh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23);
		c.nm = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59);
		c.ns = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59);
		return c;
	endfunction

	initial begin
		logic [GRACE_W-1:0] grace_steps[4];
		alarm_res_t none;
		for (int i = 0; i < MAX_ALARMS; i++) begin
			tbl_valid[i] = 0; tbl_en[i] = 0; tbl_hour[i] = 0; tbl_min[i] = 0;
			tbl_mask[i] = 0; tbl_fire[i] = 0;
		end
		base_ms = 63'd1000000000;
		none = rs(0, 0, 0, 0);

		// Directed table; fixed rows carry an expectation that is plain by inspection.
		add_row(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0), 1, none);
		add_row(mk(CMD_REMOVE, 3, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0), 1, none);
		add_row(mk(CMD_UPDATE, 3, 0, 0, 0, 1, 5, 0, 1, 0, 0, 0), 1, none);
		add_row(mk(CMD_BAD_LO, 3, 31, 63, 127, 1, MAX63, MAX63, 7, 31, 63, 63), 1, none);
		add_row(mk(CMD_BAD_HI, 31, 31, 63, 127, 1, MAX63, MAX63, 7, 31, 63, 63), 1, none);
		add_row(mk(CMD_ADD, 0, 7, 30, 0, 1, 1000, 0, 1, 0, 0, 0), 1, rs(1, 0, 0, 0));
		add_row(mk(CMD_ADD, 0, 8, 0, 0, 1, 9, 0, 1, 0, 0, 0), 1, none);
		add_row(mk(CMD_ADD, 31, 31, 63, 127, 1, 77, 0, 1, 0, 0, 0), 1, rs(1, 0, 0, 0));
		add_row(mk(CMD_ADD, 1, 0, 0, 0, 1, MAX63, 0, 1, 0, 0, 0), 1, rs(1, 0, 0, 0));
		add_row(mk(CMD_ADD, 2, 0, 0, 0, 1, 0, 0, 1, 0, 0, 0), 1, rs(1, 0, 0, 0));
		add_row(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0, 500, 0, 31, 63, 63), 0, none);
		add_row(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0, 500, 1, 0, 0, 0), 0, none);
		add_row(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0, MAX63, 4, 12, 0, 0), 1, none);
		add_row(mk(CMD_RECONCILE, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0), 1, rs(1, 0, 0, 0));
		add_row(mk(CMD_RECONCILE, 0, 0, 0, 0, 0, 0, 2000, 1, 0, 0, 0), 1, rs(1, 0, 0, 0));
		add_row(mk(CMD_RECONCILE, 0, 0, 0, 0, 0, 0, 2000, 1, 0, 0, 0), 1, none);
		add_row(mk(CMD_UPDATE, 31, 5, 5, 0, 1, 5000, 0, 1, 0, 0, 0), 1, rs(1, 0, 0, 0));
		add_row(mk(CMD_ADD, 4, 23, 59, 1, 1, 123, 0, 1, 0, 0, 0), 1, rs(1, 0, 0, 0));
		add_row(mk(CMD_ADD, 5, 6, 0, 64, 1, 0, 0, 1, 0, 0, 0), 1, rs(1, 0, 0, 0));
		add_row(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0, 4000, 7, 23, 59, 59), 0, none);
		add_row(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0, 4000, 1, 23, 59, 0), 0, none);
		add_row(mk(CMD_REMOVE, 31, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0), 1, rs(1, 0, 0, 0));
		add_row(mk(CMD_REMOVE, 31, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0), 1, none);
		add_row(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0, 100, 3, 10, 20, 30), 0, none);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_cmd(rows[i].c, rows[i].fixed, rows[i].r, 0);

		// Random phases, each under a different grace setting.
		grace_steps[0] = '0;
		grace_steps[1] = '1;
		grace_steps[2] = 32'd50000;
		grace_steps[3] = $urandom;
		for (int ph = 0; ph < 4; ph++) begin
			write_grace(grace_steps[ph]);
			for (int n = 0; n < 410; n++) begin
				// Some stretches run back to back with no idle cycles.
				send_cmd(random_cmd(), 0, none, (n % 100) >= 30);
			end
		end

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
